@@ src/rdbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rdbs_pkg
// Shared types, constants and helpers of the radix digit blink sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdbs_pkg;

	// Field and register widths
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned VALUE_W = 15;
	localparam int unsigned RADIX_W = 8;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ADDR_W  = 4;

	// Divider steps: one quotient bit per cycle
	localparam int unsigned DIV_STEPS = VALUE_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [TICK_W-1:0] RST_BLINK     = 16'd150;
	localparam logic [TICK_W-1:0] RST_SEPARATOR = 16'd300;
	localparam logic [TICK_W-1:0] RST_HEADER    = 16'd600;
	localparam logic [TICK_W-1:0] RST_SHORT     = 16'd50;

	localparam logic [RADIX_W-1:0] MIN_RADIX = 8'd2;

	// Register indexes (word address)
	typedef enum logic [1:0] {
		REG_BLINK     = 2'd0,
		REG_SEPARATOR = 2'd1,
		REG_HEADER    = 2'd2,
		REG_SHORT     = 2'd3
	} reg_idx_t;

	// Pattern phases
	typedef enum logic [11:0] {
		PH_IDLE      = 12'b0000_0000_0001,
		PH_HDR_ON    = 12'b0000_0000_0010,
		PH_HDR_OFF   = 12'b0000_0000_0100,
		PH_BL_ON     = 12'b0000_0000_1000,
		PH_BL_OFF    = 12'b0000_0001_0000,
		PH_SEP       = 12'b0000_0010_0000,
		PH_SH_ON1    = 12'b0000_0100_0000,
		PH_SH_OFF1   = 12'b0000_1000_0000,
		PH_SH_ON2    = 12'b0001_0000_0000,
		PH_GAP_SHORT = 12'b0010_0000_0000,
		PH_GAP_SEP   = 12'b0100_0000_0000,
		PH_GAP_BLINK = 12'b1000_0000_0000
	} phase_t;

	// Controller states
	typedef enum logic [1:0] {
		CS_IDLE = 2'b01,
		CS_DIV  = 2'b10
	} ctrl_state_t;

	// Segment lengths from the register file
	typedef struct packed {
		logic [TICK_W-1:0] blink_ticks;
		logic [TICK_W-1:0] separator_ticks;
		logic [TICK_W-1:0] header_ticks;
		logic [TICK_W-1:0] short_ticks;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic div_step;
		logic div_finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
	} sts_t;

	// A zero length segment lasts one tick
	function automatic logic [TICK_W-1:0] seg_len(input logic [TICK_W-1:0] r);
		seg_len = (r == '0) ? TICK_W'(1) : r;
	endfunction

	// LED level shown during a phase
	function automatic logic level_of(input phase_t ph);
		level_of = (ph == PH_HDR_ON) || (ph == PH_BL_ON) ||
			(ph == PH_SH_ON1) || (ph == PH_SH_ON2);
	endfunction

endpackage

`default_nettype wire

@@ src/rdbs_regs.sv @@
// ----------------------------------------------------------------------------
// rdbs_regs
// APB register file holding the four segment lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdbs_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [rdbs_pkg::ADDR_W-1:0]  paddr,
	input  wire  [rdbs_pkg::DATA_W-1:0]  pwdata,
	output logic [rdbs_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output rdbs_pkg::cfg_t               cfg
);
	import rdbs_pkg::*;

	logic [TICK_W-1:0] blink_q;
	logic [TICK_W-1:0] separator_q;
	logic [TICK_W-1:0] header_q;
	logic [TICK_W-1:0] short_q;
	reg_idx_t          idx;
	logic              wr_en;
	logic [TICK_W-1:0] rd_val;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q     <= RST_BLINK;
			separator_q <= RST_SEPARATOR;
			header_q    <= RST_HEADER;
			short_q     <= RST_SHORT;
		end else if (wr_en) begin
			case (idx)
				REG_BLINK:     blink_q     <= pwdata[TICK_W-1:0];
				REG_SEPARATOR: separator_q <= pwdata[TICK_W-1:0];
				REG_HEADER:    header_q    <= pwdata[TICK_W-1:0];
				REG_SHORT:     short_q     <= pwdata[TICK_W-1:0];
				default:       ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_BLINK:     rd_val = blink_q;
			REG_SEPARATOR: rd_val = separator_q;
			REG_HEADER:    rd_val = header_q;
			REG_SHORT:     rd_val = short_q;
			default:       rd_val = '0;
		endcase
	end
	assign prdata = {{(DATA_W-TICK_W){1'b0}}, rd_val};

	assign cfg.blink_ticks     = blink_q;
	assign cfg.separator_ticks = separator_q;
	assign cfg.header_ticks    = header_q;
	assign cfg.short_ticks     = short_q;

endmodule

`default_nettype wire

@@ src/rdbs_datapath.sv @@
// ----------------------------------------------------------------------------
// rdbs_datapath
// Pattern state, tick counters, digit divider and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdbs_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  rdbs_pkg::cmd_t               cmd,
	input  rdbs_pkg::cfg_t               cfg,
	input  wire                          mode,
	input  wire  [rdbs_pkg::VALUE_W-1:0] value,
	input  wire  [rdbs_pkg::RADIX_W-1:0] radix,
	output rdbs_pkg::sts_t               sts,
	output logic                         led,
	output logic                         busy_res,
	output logic                         done_res
);
	import rdbs_pkg::*;

	// Pattern state
	phase_t             phase_q;
	logic [VALUE_W-1:0] remaining_q;
	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] blinks_q;
	logic [TICK_W-1:0]  ticks_q;

	// Divider working registers
	logic [RADIX_W-1:0] div_rem_q;
	logic [VALUE_W-1:0] div_quo_q;

	// Result registers
	logic led_q;
	logic busy_q;
	logic done_q;

	// Next values for an item
	phase_t             phase_d;
	logic [VALUE_W-1:0] remaining_d;
	logic [RADIX_W-1:0] radix_d;
	logic [RADIX_W-1:0] blinks_d;
	logic [TICK_W-1:0]  ticks_d;
	logic               led_d;
	logic               busy_d;
	logic               done_d;
	logic               need_div;
	logic [TICK_W-1:0]  tl_dec;
	logic [RADIX_W-1:0] bl_dec;

	// Divider step
	logic [RADIX_W:0]   rem_sh;
	logic               ge;
	logic [RADIX_W-1:0] rem_n;
	logic [VALUE_W-1:0] quo_n;

	assign tl_dec = ticks_q - {{(TICK_W-1){1'b0}}, (ticks_q != '0)};
	assign bl_dec = blinks_q - {{(RADIX_W-1){1'b0}}, (blinks_q != '0)};

	// Work out the effect of one item
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		radix_d     = radix_q;
		blinks_d    = blinks_q;
		ticks_d     = ticks_q;
		led_d       = 1'b0;
		busy_d      = (phase_q != PH_IDLE);
		done_d      = 1'b0;
		need_div    = 1'b0;
		if (mode) begin
			if (phase_q == PH_IDLE) begin
				remaining_d = value;
				radix_d     = (radix < MIN_RADIX) ? MIN_RADIX : radix;
				blinks_d    = '0;
				phase_d     = PH_HDR_ON;
				ticks_d     = seg_len(cfg.header_ticks);
				busy_d      = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			led_d   = level_of(phase_q);
			ticks_d = tl_dec;
			if (tl_dec == '0) begin
				case (phase_q)
					PH_HDR_ON: begin
						phase_d = PH_HDR_OFF;
						ticks_d = seg_len(cfg.header_ticks);
					end
					PH_BL_ON: begin
						phase_d = PH_BL_OFF;
						ticks_d = seg_len(cfg.blink_ticks);
					end
					PH_BL_OFF: begin
						blinks_d = bl_dec;
						if (bl_dec != '0) begin
							phase_d = PH_BL_ON;
							ticks_d = seg_len(cfg.blink_ticks);
						end else begin
							phase_d = PH_SEP;
							ticks_d = seg_len(cfg.separator_ticks);
						end
					end
					PH_SEP: begin
						phase_d = PH_SH_ON1;
						ticks_d = seg_len(cfg.short_ticks);
					end
					PH_SH_ON1: begin
						phase_d = PH_SH_OFF1;
						ticks_d = seg_len(cfg.short_ticks);
					end
					PH_SH_OFF1: begin
						phase_d = PH_SH_ON2;
						ticks_d = seg_len(cfg.short_ticks);
					end
					PH_SH_ON2: begin
						phase_d = PH_GAP_SHORT;
						ticks_d = seg_len(cfg.short_ticks);
					end
					PH_GAP_SHORT: begin
						phase_d = PH_GAP_SEP;
						ticks_d = seg_len(cfg.separator_ticks);
					end
					PH_GAP_SEP: begin
						phase_d = PH_GAP_BLINK;
						ticks_d = seg_len(cfg.blink_ticks);
					end
					PH_HDR_OFF, PH_GAP_BLINK: begin
						// Open the next digit, or finish when nothing is left
						if (remaining_q == '0) begin
							phase_d  = PH_IDLE;
							ticks_d  = '0;
							blinks_d = '0;
							busy_d   = 1'b0;
							done_d   = 1'b1;
						end else begin
							need_div = 1'b1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						ticks_d = '0;
						busy_d  = 1'b0;
					end
				endcase
			end
		end
	end

	assign sts.need_div = need_div;

	// Restoring division: one quotient bit per step
	assign rem_sh = {div_rem_q, div_quo_q[VALUE_W-1]};
	assign ge     = (rem_sh >= {1'b0, radix_q});
	assign rem_n  = ge ? RADIX_W'(rem_sh - {1'b0, radix_q}) : rem_sh[RADIX_W-1:0];
	assign quo_n  = {div_quo_q[VALUE_W-2:0], ge};

	// Pattern state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= '0;
			radix_q     <= MIN_RADIX;
			blinks_q    <= '0;
			ticks_q     <= '0;
		end else if (cmd.take) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			radix_q     <= radix_d;
			blinks_q    <= blinks_d;
			ticks_q     <= ticks_d;
		end else if (cmd.div_finish) begin
			remaining_q <= quo_n;
			blinks_q    <= rem_n;
			if (rem_n != '0) begin
				phase_q <= PH_BL_ON;
				ticks_q <= seg_len(cfg.blink_ticks);
			end else begin
				phase_q <= PH_SEP;
				ticks_q <= seg_len(cfg.separator_ticks);
			end
		end
	end

	// Divider load and shift
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			div_rem_q <= '0;
			div_quo_q <= remaining_q;
		end else if (cmd.div_step) begin
			div_rem_q <= rem_n;
			div_quo_q <= quo_n;
		end
	end

	// Capture the result of an item
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			led_q  <= led_d;
			busy_q <= busy_d;
			done_q <= done_d;
		end
	end

	assign led      = led_q;
	assign busy_res = busy_q;
	assign done_res = done_q;

endmodule

`default_nettype wire

@@ src/rdbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdbs_ctrl
// Handshake and divider sequencing for the blink sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdbs_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire             out_ready,
	input  rdbs_pkg::sts_t  sts,
	output rdbs_pkg::cmd_t  cmd
);
	import rdbs_pkg::*;

	ctrl_state_t          state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 take;
	logic                 last_step;

	assign in_ready  = (state_q == CS_IDLE) && (!out_valid_q || out_ready);
	assign take      = in_valid && in_ready;
	assign last_step = (state_q == CS_DIV) && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	assign cmd.take       = take;
	assign cmd.div_step   = (state_q == CS_DIV);
	assign cmd.div_finish = last_step;

	// Sequence: accept, then divide when a digit opens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				CS_IDLE: begin
					cnt_q <= '0;
					if (take && sts.need_div) begin
						state_q <= CS_DIV;
					end
				end
				CS_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (last_step) begin
						state_q <= CS_IDLE;
					end
				end
				default: begin
					state_q <= CS_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((take && !sts.need_div) || last_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ src/radix_digit_blink_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// radix_digit_blink_sequencer_top
// Shows a number on one LED as a blink code, one tick item at a time.
// ----------------------------------------------------------------------------
// A start item (mode 1) loads a value and a radix (below 2 taken as 2); each
// tick item (mode 0) advances the pattern by one time unit and returns the LED
// level for it. The pattern is a header on/off, then per digit, least
// significant first, that many blinks, a separator gap, two short pulses and a
// closing gap. Every item returns exactly one result. A start item, or a tick
// that stays inside the current digit, has its result in the cycle after it is
// accepted; a tick that opens a new digit waits for the restoring divider,
// which produces one quotient bit per cycle over the 15-bit value. The next item is
// accepted once the divider is free and the result register is empty or being
// read. Segment lengths sit in four 16-bit APB registers at byte addresses
// 0x0, 0x4, 0x8, 0xC (blink, separator, header, short); change them only while
// the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_blink_sequencer_top (
	input  wire                          clk,
	input  wire                          arst_n,
	// Configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [rdbs_pkg::ADDR_W-1:0]  paddr,
	input  wire  [rdbs_pkg::DATA_W-1:0]  pwdata,
	output logic [rdbs_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	// Input items
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          mode,
	input  wire  [rdbs_pkg::VALUE_W-1:0] value,
	input  wire  [rdbs_pkg::RADIX_W-1:0] radix,
	// Result items
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         led,
	output logic                         busy_res,
	output logic                         done_res
);
	import rdbs_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	rdbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rdbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rdbs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.mode     (mode),
		.value    (value),
		.radix    (radix),
		.sts      (sts),
		.led      (led),
		.busy_res (busy_res),
		.done_res (done_res)
	);

endmodule

`default_nettype wire

@@ tb/radix_digit_blink_sequencer_top_tb.sv @@
// ----------------------------------------------------------------------------
// radix_digit_blink_sequencer_top_tb
// Self-checking bench for the LED blink code sequencer.
// ----------------------------------------------------------------------------
// Segment lengths are loaded over APB and read back. A short table of directed
// items then runs: idle ticks, ignored starts, the header alone, the largest
// radix, the largest value, zero digits and a radix below two. Four random
// phases follow, each under its own segment lengths and its own sender/receiver
// pacing. Each phase runs short whole patterns with random content and a little
// noise. A last pass opens a header with every register at its maximum. Every
// result is compared to its typed value or to a cycle-free model of the pattern kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_blink_sequencer_top_tb;
	import rdbs_pkg::*;

	localparam logic        MODE_TICK     = 1'b0;
	localparam logic        MODE_START    = 1'b1;
	localparam logic        APB_READ      = 1'b0;
	localparam logic        APB_WRITE     = 1'b1;
	localparam int unsigned CYCLE_LIMIT   = 3_000_000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASE_ITEMS   = 30;
	localparam int unsigned PATTERN_CAP   = 48;

	typedef enum logic [1:0] {
		PACE_NONE,
		PACE_SRC,
		PACE_SINK,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic led;
		logic busy;
		logic done;
	} blink_res_t;

	localparam blink_res_t RES_QUIET = 3'b000;
	localparam blink_res_t RES_BUSY  = 3'b010;
	localparam blink_res_t RES_LIT   = 3'b110;
	localparam blink_res_t RES_DONE  = 3'b001;

	// One directed row; a repeat count of RUN_OUT ticks until the pattern ends
	typedef struct packed {
		logic               m;
		logic [VALUE_W-1:0] v;
		logic [RADIX_W-1:0] r;
		logic [15:0]        reps;
		logic               typed;
		blink_res_t         want;
	} drow_t;

	localparam logic [15:0] RUN_OUT = 16'd0;
	localparam int unsigned N_DIRECTED = 21;

	localparam drow_t DIRECTED [N_DIRECTED] = '{
		// idle tick, then the header alone with an ignored start inside it
		'{MODE_TICK,  15'd0,      8'd0,   16'd1, 1'b1, RES_QUIET},
		'{MODE_START, 15'd0,      8'd0,   16'd1, 1'b1, RES_BUSY},
		'{MODE_START, 15'h7FFF,   8'hFF,  16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   16'd1, 1'b1, RES_LIT},
		'{MODE_TICK,  15'd0,      8'd0,   16'd1, 1'b1, RES_DONE},
		'{MODE_TICK,  15'd0,      8'd0,   16'd1, 1'b1, RES_QUIET},
		// largest radix: a zero digit, then a three
		'{MODE_START, 15'd765,    8'hFF,  16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   RUN_OUT, 1'b0, RES_QUIET},
		// largest value in binary: fifteen one digits
		'{MODE_START, 15'h7FFF,   8'd2,   16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   RUN_OUT, 1'b0, RES_QUIET},
		// radix below two
		'{MODE_START, 15'd1,      8'd1,   16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   RUN_OUT, 1'b0, RES_QUIET},
		// zero digits
		'{MODE_START, 15'd4,      8'd2,   16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   RUN_OUT, 1'b0, RES_QUIET},
		'{MODE_START, 15'd10,     8'd10,  16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   RUN_OUT, 1'b0, RES_QUIET},
		// start inside a digit is ignored
		'{MODE_START, 15'd7,      8'd3,   16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   16'd3, 1'b0, RES_QUIET},
		'{MODE_START, 15'd1,      8'd2,   16'd1, 1'b1, RES_BUSY},
		'{MODE_TICK,  15'd0,      8'd0,   RUN_OUT, 1'b0, RES_QUIET},
		'{MODE_TICK,  15'h2AAA,   8'h55,  16'd1, 1'b1, RES_QUIET}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic [VALUE_W-1:0] value;
	logic [RADIX_W-1:0] radix;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               led;
	logic               busy_res;
	logic               done_res;

	// Pattern model state and its copy of the registers
	logic [TICK_W-1:0]  seg_regs [4] = '{RST_BLINK, RST_SEPARATOR, RST_HEADER, RST_SHORT};
	phase_t             pat_phase   = PH_IDLE;
	logic [VALUE_W-1:0] digits_left = '0;
	logic [RADIX_W-1:0] pat_base    = MIN_RADIX;
	logic [7:0]         blinks_left = '0;
	logic [TICK_W-1:0]  seg_left    = '0;

	blink_res_t  expected_levels [$];
	pace_t       pace = PACE_NONE;
	int unsigned errors = 0;
	int unsigned live_items = 0;
	int unsigned cycle_count;

	radix_digit_blink_sequencer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.radix     (radix),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.led       (led),
		.busy_res  (busy_res),
		.done_res  (done_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Start a segment; a zero length lasts one tick
	function automatic void enter_segment(input phase_t p, input logic [TICK_W-1:0] len);
		pat_phase = p;
		seg_left  = (len == '0) ? TICK_W'(1) : len;
	endfunction

	// Split off the next digit, or finish when nothing is left
	function automatic bit open_digit();
		if (digits_left == '0) begin
			pat_phase   = PH_IDLE;
			seg_left    = '0;
			blinks_left = '0;
			return 1'b1;
		end
		blinks_left = 8'(digits_left % pat_base);
		digits_left = digits_left / pat_base;
		if (blinks_left != '0)
			enter_segment(PH_BL_ON, seg_regs[REG_BLINK]);
		else
			enter_segment(PH_SEP, seg_regs[REG_SEPARATOR]);
		return 1'b0;
	endfunction

	// Move past a finished segment; true when the whole pattern is done
	function automatic bit close_segment();
		case (pat_phase)
			PH_HDR_ON: begin
				enter_segment(PH_HDR_OFF, seg_regs[REG_HEADER]);
			end
			PH_HDR_OFF, PH_GAP_BLINK: begin
				return open_digit();
			end
			PH_BL_ON: begin
				enter_segment(PH_BL_OFF, seg_regs[REG_BLINK]);
			end
			PH_BL_OFF: begin
				if (blinks_left != '0)
					blinks_left--;
				if (blinks_left != '0)
					enter_segment(PH_BL_ON, seg_regs[REG_BLINK]);
				else
					enter_segment(PH_SEP, seg_regs[REG_SEPARATOR]);
			end
			PH_SEP:       enter_segment(PH_SH_ON1, seg_regs[REG_SHORT]);
			PH_SH_ON1:    enter_segment(PH_SH_OFF1, seg_regs[REG_SHORT]);
			PH_SH_OFF1:   enter_segment(PH_SH_ON2, seg_regs[REG_SHORT]);
			PH_SH_ON2:    enter_segment(PH_GAP_SHORT, seg_regs[REG_SHORT]);
			PH_GAP_SHORT: enter_segment(PH_GAP_SEP, seg_regs[REG_SEPARATOR]);
			PH_GAP_SEP:   enter_segment(PH_GAP_BLINK, seg_regs[REG_BLINK]);
			default: begin
				pat_phase = PH_IDLE;
				seg_left  = '0;
			end
		endcase
		return 1'b0;
	endfunction

	// Apply one accepted item to the pattern and return its result
	function automatic blink_res_t advance_pattern(input logic m, input logic [VALUE_W-1:0] v,
			input logic [RADIX_W-1:0] r);
		blink_res_t res;
		res = RES_QUIET;
		if (m == MODE_START) begin
			if (pat_phase == PH_IDLE) begin
				digits_left = v;
				pat_base    = (r < MIN_RADIX) ? MIN_RADIX : r;
				blinks_left = '0;
				enter_segment(PH_HDR_ON, seg_regs[REG_HEADER]);
			end
		end else if (pat_phase != PH_IDLE) begin
			res.led = (pat_phase == PH_HDR_ON) || (pat_phase == PH_BL_ON) ||
				(pat_phase == PH_SH_ON1) || (pat_phase == PH_SH_ON2);
			if (seg_left != '0)
				seg_left--;
			if (seg_left == '0)
				res.done = close_segment();
		end
		res.busy = (pat_phase != PH_IDLE);
		return res;
	endfunction

	// Ticks a whole pattern takes under the current segment lengths
	function automatic int unsigned pattern_ticks(input logic [VALUE_W-1:0] v,
			input logic [RADIX_W-1:0] r);
		int unsigned        n;
		int unsigned        bl;
		int unsigned        sp;
		int unsigned        sh;
		logic [VALUE_W-1:0] rest;
		logic [RADIX_W-1:0] base;
		bl   = int'(seg_len(seg_regs[REG_BLINK]));
		sp   = int'(seg_len(seg_regs[REG_SEPARATOR]));
		sh   = int'(seg_len(seg_regs[REG_SHORT]));
		n    = 2 * int'(seg_len(seg_regs[REG_HEADER]));
		base = (r < MIN_RADIX) ? MIN_RADIX : r;
		rest = v;
		while (rest != '0) begin
			n    = n + 2 * int'(rest % base) * bl + 2 * sp + 4 * sh + bl;
			rest = rest / base;
		end
		return n;
	endfunction

	// Roll whether a side holds off for this cycle
	function automatic bit holds_off(input bit sender);
		int unsigned pct;
		case (pace)
			PACE_SRC:  pct = sender ? 79 : 0;
			PACE_SINK: pct = sender ? 0 : 79;
			PACE_BOTH: pct = 33;
			default:   pct = 0;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic void compare_field(input string field, input logic want, input logic got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %0b, got %0b", $time, field, want, got);
		end
	endfunction

	// Offer one item, hold it until taken, then log its expected result
	task automatic push_item(input logic m, input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
			input logic typed, input blink_res_t want);
		blink_res_t res;
		while (holds_off(1'b1)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		radix    <= r;
		do
			@(posedge clk);
		while (!in_ready);
		if ((m == MODE_START) == (pat_phase == PH_IDLE))
			live_items++;
		res = advance_pattern(m, v, r);
		expected_levels.push_back(typed ? want : res);
		@(negedge clk);
	endtask

	// One APB transfer; a read is checked against the expected value
	task automatic reg_access(input logic wr, input reg_idx_t idx, input logic [TICK_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(data);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (wr == APB_WRITE) begin
			seg_regs[idx] = data;
		end else if (prdata !== DATA_W'(data)) begin
			errors++;
			$display("%0t ns: register %s expected %0h, got %0h", $time, idx.name(), data, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write all four segment lengths, then read them back
	task automatic load_cfg(input logic [TICK_W-1:0] blink, sep, hdr, shrt);
		logic [TICK_W-1:0] vals [4];
		vals = '{blink, sep, hdr, shrt};
		for (int i = 0; i < 4; i++)
			reg_access(APB_WRITE, reg_idx_t'(i), vals[i]);
		for (int i = 0; i < 4; i++)
			reg_access(APB_READ, reg_idx_t'(i), seg_regs[i]);
	endtask

	// Drop valid, wait for every result, then let the divider settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Short whole patterns with random content, ignored starts and idle ticks
	task automatic run_mix(input int unsigned quota);
		int unsigned first;
		int unsigned width;
		logic [VALUE_W-1:0] v;
		logic [RADIX_W-1:0] r;
		first = live_items;
		while (live_items - first < quota) begin
			if ($urandom_range(0, 99) < 85) begin
				do begin
					width = $urandom_range(0, VALUE_W);
					v = VALUE_W'($urandom) & ((VALUE_W'(1) << width) - VALUE_W'(1));
					case ($urandom_range(0, 4))
						0:       r = RADIX_W'($urandom_range(0, 1));
						1:       r = MIN_RADIX;
						2:       r = RADIX_W'($urandom_range(3, 16));
						3:       r = RADIX_W'($urandom_range(128, 255));
						default: r = RADIX_W'($urandom);
					endcase
				end while (pattern_ticks(v, r) > PATTERN_CAP);
				push_item(MODE_START, v, r, 1'b0, RES_QUIET);
				while (pat_phase != PH_IDLE) begin
					if ($urandom_range(0, 99) < 3)
						push_item(MODE_START, VALUE_W'($urandom), RADIX_W'($urandom), 1'b0, RES_QUIET);
					else
						push_item(MODE_TICK, VALUE_W'($urandom), RADIX_W'($urandom), 1'b0, RES_QUIET);
				end
			end else begin
				push_item(MODE_TICK, VALUE_W'($urandom), RADIX_W'($urandom), 1'b0, RES_QUIET);
			end
		end
	endtask

	// Stall the result side
	always @(negedge clk)
		out_ready <= !holds_off(1'b0);

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		blink_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				errors++;
				$display("%0t ns: result expected none, got led=%0b busy=%0b done=%0b",
					$time, led, busy_res, done_res);
			end else begin
				want = expected_levels.pop_front();
				compare_field("led", want.led, led);
				compare_field("busy_res", want.busy, busy_res);
				compare_field("done_res", want.done, done_res);
			end
		end
	end

	// Give up on a hung run
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		mode     = MODE_TICK;
		value    = '0;
		radix    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers
		for (int i = 0; i < 4; i++)
			reg_access(APB_READ, reg_idx_t'(i), seg_regs[i]);

		// Directed table; zero header length counts as one tick
		load_cfg(16'd1, 16'd2, 16'd0, 16'd1);
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].reps == RUN_OUT) begin
				while (pat_phase != PH_IDLE)
					push_item(DIRECTED[i].m, DIRECTED[i].v, DIRECTED[i].r,
						DIRECTED[i].typed, DIRECTED[i].want);
			end else begin
				repeat (DIRECTED[i].reps)
					push_item(DIRECTED[i].m, DIRECTED[i].v, DIRECTED[i].r,
						DIRECTED[i].typed, DIRECTED[i].want);
			end
		end
		wait_drained();

		// Random phases, each with its own lengths and pacing
		pace = PACE_NONE;
		load_cfg(16'd1, 16'd1, 16'd1, 16'd1);
		run_mix(PHASE_ITEMS);
		wait_drained();

		pace = PACE_SRC;
		load_cfg(16'd0, 16'd0, 16'd0, 16'd0);
		run_mix(PHASE_ITEMS);
		wait_drained();

		pace = PACE_SINK;
		load_cfg(TICK_W'($urandom_range(0, 3)), TICK_W'($urandom_range(0, 3)),
			TICK_W'($urandom_range(0, 3)), TICK_W'($urandom_range(0, 3)));
		run_mix(PHASE_ITEMS);
		wait_drained();

		pace = PACE_BOTH;
		load_cfg(TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)),
			TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)));
		run_mix(PHASE_ITEMS);
		wait_drained();

		// Open the longest header at full register values
		pace = PACE_NONE;
		load_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_item(MODE_START, 15'd0, 8'd0, 1'b1, RES_BUSY);
		repeat (4)
			push_item(MODE_TICK, 15'd0, 8'd0, 1'b1, RES_LIT);
		wait_drained();

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
